[hw/rtl/fct_pkg.sv]
// Shared types and constants of the flow counter table.
package fct_pkg;

    typedef struct packed {
        logic [31:0] addr;
        logic [15:0] port;
    } key_t;

    localparam logic [1:0]  ST_COUNTED = 2'd0;
    localparam logic [1:0]  ST_CLEARED = 2'd1;
    localparam logic [1:0]  ST_FULL    = 2'd2;
    localparam logic [1:0]  ST_DROPPED = 2'd3;

    localparam logic [31:0] EXIT_WORD         = 32'h6578_6974;  // "exit"
    localparam logic [15:0] LISTEN_PORT_RESET = 16'd5000;
    localparam logic [31:0] COUNT_MAX         = 32'hFFFF_FFFF;
    localparam logic [2:0]  EXIT_LEN          = 3'd4;

endpackage

[hw/rtl/flow_counter_table.sv]
// Top level of the per-flow datagram counter table.
//
// One transaction on the input channel carries the header summary of a UDP
// datagram; exactly one result transaction follows. Datagrams whose
// destination port differs from listen_port (reset 5000, written through the
// cfg channel; the user must write it only while idle, as the block does not
// enforce it) are dropped with status 3. Others are looked up by (source
// address, source port) in a fully associative table of TABLE_ENTRIES
// entries; a miss allocates the next free entry, or reports table full
// (status 2) when none is left. Entries are never freed. A payload starting
// with "exit" (four head bytes present) clears the counter (status 1);
// otherwise the counter increments and saturates at all ones (status 0).
// Timing: one datagram at a time. A hit passes through accept, key compare
// into the match register, counter memory read, then update and write back;
// a miss, drop or full verdict skips the counter read. Each waits in its
// last step while the output register is full and not being taken. The
// result sits in an output register, so a new datagram is accepted while it
// waits to be taken.
// No clearing pass after reset: the fill count marks which entries are live.
module flow_counter_table #(
    parameter int TABLE_ENTRIES = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    // configuration write
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data,
    // datagram summaries
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] src_ip,
    input  logic [15:0] src_port,
    input  logic [15:0] dst_port,
    input  logic [31:0] payload_head,
    input  logic [2:0]  head_bytes,
    // results
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  status,
    output logic [3:0]  entry_index,
    output logic [31:0] flow_count
);
    import fct_pkg::*;

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
    localparam logic [CNT_W-1:0] USED_FULL = CNT_W'(TABLE_ENTRIES);

    // sequencer states
    localparam logic [1:0] S_IDLE = 2'd0;  // waiting for a transaction
    localparam logic [1:0] S_LOOK = 2'd1;  // key compare in flight
    localparam logic [1:0] S_DEC  = 2'd2;  // verdict, allocate or read counter
    localparam logic [1:0] S_UPD  = 2'd3;  // counter back from memory

    logic [1:0]       state_reg, state_next;
    logic [15:0]      listen_port_reg;
    logic [CNT_W-1:0] used_reg, used_next;

    // captured datagram
    key_t             key_reg;
    logic             drop_reg;
    logic             exit_reg;
    logic [IDX_W-1:0] slot_reg, slot_next;

    // output register
    logic             out_valid_reg, out_valid_next;
    logic [1:0]       status_reg, status_next;
    logic [3:0]       entry_index_reg, entry_index_next;
    logic [31:0]      flow_count_reg, flow_count_next;

    logic             out_free;
    logic             in_fire;
    logic             emit;
    logic [1:0]       emit_status;
    logic [IDX_W-1:0] emit_slot;
    logic [31:0]      emit_count;
    logic [IDX_W+3:0] slot_wide;

    logic             cam_hit;
    logic [IDX_W-1:0] cam_idx;
    logic             key_we;
    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    logic [31:0]      ram_wdata;
    logic             ram_re;
    logic [31:0]      ram_rdata;
    logic [31:0]      count_inc;

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == S_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;

    fct_key_cam #(
        .ENTRIES (TABLE_ENTRIES),
        .IDX_W   (IDX_W),
        .CNT_W   (CNT_W)
    ) u_cam (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (key_we),
        .wr_idx   (used_reg[IDX_W-1:0]),
        .wr_key   (key_reg),
        .look_key (key_reg),
        .used     (used_reg),
        .hit      (cam_hit),
        .hit_idx  (cam_idx)
    );

    fct_count_ram #(
        .DEPTH (TABLE_ENTRIES),
        .AW    (IDX_W)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (cam_idx),
        .rdata (ram_rdata)
    );

    // saturating increment of the stored counter
    assign count_inc = (ram_rdata == COUNT_MAX) ? COUNT_MAX : ram_rdata + 32'd1;

    always_comb
    begin
        state_next  = state_reg;
        used_next   = used_reg;
        slot_next   = slot_reg;
        emit        = 1'b0;
        emit_status = ST_COUNTED;
        emit_slot   = '0;
        emit_count  = '0;
        key_we      = 1'b0;
        ram_we      = 1'b0;
        ram_waddr   = used_reg[IDX_W-1:0];
        ram_wdata   = '0;
        ram_re      = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = S_LOOK;
                end
            end
            S_LOOK:
            begin
                state_next = S_DEC;
            end
            S_DEC:
            begin
                if (drop_reg)
                begin
                    if (out_free)
                    begin
                        emit        = 1'b1;
                        emit_status = ST_DROPPED;
                        state_next  = S_IDLE;
                    end
                end
                else if (cam_hit)
                begin
                    ram_re     = 1'b1;
                    slot_next  = cam_idx;
                    state_next = S_UPD;
                end
                else if (used_reg == USED_FULL)
                begin
                    if (out_free)
                    begin
                        emit        = 1'b1;
                        emit_status = ST_FULL;
                        state_next  = S_IDLE;
                    end
                end
                else if (out_free)
                begin
                    // new flow: counter starts at zero, so no read needed
                    key_we      = 1'b1;
                    ram_we      = 1'b1;
                    ram_wdata   = exit_reg ? 32'd0 : 32'd1;
                    used_next   = used_reg + CNT_W'(1);
                    emit        = 1'b1;
                    emit_status = exit_reg ? ST_CLEARED : ST_COUNTED;
                    emit_slot   = used_reg[IDX_W-1:0];
                    emit_count  = ram_wdata;
                    state_next  = S_IDLE;
                end
            end
            S_UPD:
            begin
                if (out_free)
                begin
                    ram_we      = 1'b1;
                    ram_waddr   = slot_reg;
                    ram_wdata   = exit_reg ? 32'd0 : count_inc;
                    emit        = 1'b1;
                    emit_status = exit_reg ? ST_CLEARED : ST_COUNTED;
                    emit_slot   = slot_reg;
                    emit_count  = ram_wdata;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // entry_index carries the low four bits of the slot
    assign slot_wide = {4'b0000, emit_slot};

    always_comb
    begin
        out_valid_next   = out_valid_reg && !out_ready;
        status_next      = status_reg;
        entry_index_next = entry_index_reg;
        flow_count_next  = flow_count_reg;
        if (emit)
        begin
            out_valid_next   = 1'b1;
            status_next      = emit_status;
            entry_index_next = slot_wide[3:0];
            flow_count_next  = emit_count;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            used_reg        <= '0;
            out_valid_reg   <= 1'b0;
            listen_port_reg <= LISTEN_PORT_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            used_reg      <= used_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                listen_port_reg <= cfg_data;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            key_reg.addr <= src_ip;
            key_reg.port <= src_port;
            drop_reg     <= (dst_port != listen_port_reg);
            exit_reg     <= (head_bytes >= EXIT_LEN) && (payload_head == EXIT_WORD);
        end
        slot_reg        <= slot_next;
        status_reg      <= status_next;
        entry_index_reg <= entry_index_next;
        flow_count_reg  <= flow_count_next;
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign entry_index = entry_index_reg;
    assign flow_count  = flow_count_reg;

    // fill count never passes the table size
    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= USED_FULL)
        else $error("fill count beyond table size");

    // allocation writes key and counter of the same entry together
    a_alloc_pair: assert property (@(posedge clk) disable iff (!rst_n)
        key_we |-> (ram_we && ram_waddr == used_reg[IDX_W-1:0]))
        else $error("key written without its counter");

    // a fresh result only comes from a transaction in progress
    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> (state_reg == S_DEC || state_reg == S_UPD))
        else $error("result issued while idle");

    // the fill count only moves on an allocation
    a_used_step: assert property (@(posedge clk) disable iff (!rst_n)
        (used_reg != $past(used_reg)) |-> $past(key_we))
        else $error("fill count moved without allocation");

endmodule

[hw/rtl/fct_key_cam.sv]
// Flow key store with parallel compare and registered match vector.
module fct_key_cam #(
    parameter int ENTRIES = 16,
    parameter int IDX_W   = 4,
    parameter int CNT_W   = 5
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_idx,
    input  fct_pkg::key_t    wr_key,
    input  fct_pkg::key_t    look_key,
    input  logic [CNT_W-1:0] used,
    output logic             hit,
    output logic [IDX_W-1:0] hit_idx
);
    import fct_pkg::*;

    key_t               keys [ENTRIES];
    logic [ENTRIES-1:0] match_next;
    logic [ENTRIES-1:0] match_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            keys[wr_idx] <= wr_key;
        end
    end

    // only allocated entries take part
    always_comb
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            match_next[i] = (CNT_W'(i) < used) && (keys[i] == look_key);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_reg <= '0;
        end
        else
        begin
            match_reg <= match_next;
        end
    end

    // keys are unique, so the vector is one-hot or empty: OR the indices
    always_comb
    begin
        hit_idx = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (match_reg[i])
            begin
                hit_idx = hit_idx | IDX_W'(i);
            end
        end
    end

    assign hit = |match_reg;

endmodule

[hw/rtl/fct_count_ram.sv]
// Counter memory, one write port and one registered read port.
module fct_count_ram #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [31:0]   wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [31:0]   rdata
);
    logic [31:0] mem [DEPTH];
    logic [31:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[bench/flow_counter_checker.sv]
// Result checker for the flow counter table: predicts every reply and compares it.
module flow_counter_checker #(
    parameter int TABLE_ENTRIES = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [31:0] src_ip,
    input  logic [15:0] src_port,
    input  logic [15:0] dst_port,
    input  logic [31:0] payload_head,
    input  logic [2:0]  head_bytes,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [1:0]  status,
    input  logic [3:0]  entry_index,
    input  logic [31:0] flow_count,
    output int          errors,
    output int          awaited
);
    import fct_pkg::*;

    typedef struct packed {
        logic [1:0]  status;
        logic [3:0]  entry;
        logic [31:0] count;
    } reply_t;

    reply_t      pending_replies[$];
    reply_t      want;
    logic [31:0] flow_addr [TABLE_ENTRIES];
    logic [15:0] flow_port [TABLE_ENTRIES];
    logic [31:0] flow_hits [TABLE_ENTRIES];
    int          flows_used;
    logic [15:0] listen_port;

    initial errors = 0;

    task automatic report(string msg);
        $display("%0t: mismatch: %s", $time, msg);
        errors++;
    endtask

    // Own copy of the table: lookup, allocate, then clear or count.
    function automatic reply_t tally_datagram(logic [31:0] ip, logic [15:0] sport,
                                              logic [15:0] dport, logic [31:0] head,
                                              logic [2:0] nbytes);
        reply_t r;
        int     slot;
        int     i;
        r    = '0;
        slot = -1;
        if (dport != listen_port)
        begin
            r.status = ST_DROPPED;
            return r;
        end
        for (i = 0; i < flows_used; i++)
            if (slot < 0 && flow_addr[i] == ip && flow_port[i] == sport)
                slot = i;
        if (slot < 0)
        begin
            if (flows_used >= TABLE_ENTRIES)
            begin
                r.status = ST_FULL;
                return r;
            end
            slot            = flows_used;
            flow_addr[slot] = ip;
            flow_port[slot] = sport;
            flow_hits[slot] = '0;
            flows_used++;
        end
        r.entry = 4'(slot);
        if (nbytes >= EXIT_LEN && head == EXIT_WORD)
        begin
            flow_hits[slot] = '0;
            r.status        = ST_CLEARED;
        end
        else
        begin
            if (flow_hits[slot] != COUNT_MAX)
                flow_hits[slot]++;
            r.status = ST_COUNTED;
            r.count  = flow_hits[slot];
        end
        return r;
    endfunction

    // Replies are popped before new predictions are pushed in the same cycle.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flows_used  = 0;
            listen_port = LISTEN_PORT_RESET;
            pending_replies.delete();
            awaited     = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                listen_port = cfg_data;
            if (out_valid && out_ready)
            begin
                if (pending_replies.size() == 0)
                    report($sformatf("result status %0d entry %0d count %0h with none due",
                                     status, entry_index, flow_count));
                else
                begin
                    want = pending_replies.pop_front();
                    if (status !== want.status)
                        report($sformatf("status %0d, expected %0d", status, want.status));
                    if (entry_index !== want.entry)
                        report($sformatf("entry_index %0d, expected %0d",
                                         entry_index, want.entry));
                    if (flow_count !== want.count)
                        report($sformatf("flow_count %0h, expected %0h",
                                         flow_count, want.count));
                end
            end
            if (in_valid && in_ready)
                pending_replies.push_back(tally_datagram(src_ip, src_port, dst_port,
                                                         payload_head, head_bytes));
            awaited = pending_replies.size();
        end
    end

endmodule

[bench/tb_flow_counter_table.sv]
// Testbench top of the flow counter table: clock, reset, stimulus and verdict.
module tb_flow_counter_table;
    import fct_pkg::*;

    localparam int TABLE_ENTRIES = 16;
    localparam int POOL_KEYS     = 24;   // more flows than entries, so the table fills
    localparam int PHASE_ITEMS   = 320;  // random datagrams per listen port setting
    localparam int CALM_ITEMS    = 150;  // closing stretch with no idling on either side

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [15:0] cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic [31:0] src_ip;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [31:0] payload_head;
    logic [2:0]  head_bytes;
    logic        out_valid;
    logic        out_ready;
    logic [1:0]  status;
    logic [3:0]  entry_index;
    logic [31:0] flow_count;

    int          errors;
    int          awaited;        // replies still due, kept by the checker
    logic        quiet = 1'b0;   // closing stretch: no idling anywhere
    logic [15:0] listen_port;    // our note of what the block is listening on
    key_t        flow_keys [POOL_KEYS];

    flow_counter_table #(.TABLE_ENTRIES(TABLE_ENTRIES)) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .src_ip       (src_ip),
        .src_port     (src_port),
        .dst_port     (dst_port),
        .payload_head (payload_head),
        .head_bytes   (head_bytes),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .entry_index  (entry_index),
        .flow_count   (flow_count)
    );

    flow_counter_checker #(.TABLE_ENTRIES(TABLE_ENTRIES)) flow_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .src_ip       (src_ip),
        .src_port     (src_port),
        .dst_port     (dst_port),
        .payload_head (payload_head),
        .head_bytes   (head_bytes),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .entry_index  (entry_index),
        .flow_count   (flow_count),
        .errors       (errors),
        .awaited      (awaited)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Watchdog. The worst honest run is roughly 1600 datagrams, each with a
    // sender gap and a result stall at their longest, plus two long hold-offs;
    // the watchdog fails the run if it is still going at its limit.
    initial
    begin
        #3_000_000;
        $display("simulation failed");
        $finish;
    end

    // Result side. Ready alternates between random stalls and ready stretches.
    // Twice, at fixed points in time, it holds off while the sender keeps
    // offering, so the output register fills and in_ready drops. In the closing
    // stretch it stays high.
    initial
    begin : result_taker
        int stall;
        int run;
        int ticks;
        stall     = 0;
        run       = 0;
        ticks     = 0;
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            ticks++;
            if (ticks == 3000 || ticks == 9000)
                stall = 80;
            else if (stall == 0 && run == 0)
            begin
                if ($urandom_range(0, 2) == 0)
                    stall = $urandom_range(1, 17);
                else
                    run = $urandom_range(1, 60);
            end
            if (quiet)
            begin
                stall = 0;
                run   = 0;
            end
            out_ready = quiet || stall == 0;
            if (stall > 0)
                stall--;
            else if (run > 0)
                run--;
        end
    end

    // One datagram transaction: drive at the falling edge, hold until taken.
    // Returns at the accepting rising edge with valid still high, so the
    // next call or a pause decides at the next falling edge.
    task automatic offer(key_t key, logic [15:0] dport, logic [31:0] head,
                         logic [2:0] nbytes);
        @(negedge clk);
        in_valid     = 1'b1;
        src_ip       = key.addr;
        src_port     = key.port;
        dst_port     = dport;
        payload_head = head;
        head_bytes   = nbytes;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    task automatic pause_sender(int cycles);
        @(negedge clk);
        in_valid = 1'b0;
        repeat (cycles - 1) @(negedge clk);
    endtask

    // Stop offering and wait until every reply has been taken.
    task automatic drain();
        @(negedge clk);
        in_valid = 1'b0;
        while (awaited != 0)
            @(negedge clk);
    endtask

    // The register may only change with nothing in flight.
    task automatic set_listen_port(logic [15:0] port);
        drain();
        cfg_valid = 1'b1;
        cfg_data  = port;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid   = 1'b0;
        listen_port = port;
    endtask

    // Mostly flows from the pool, counted on the listen port; some stray
    // flows, wrong or near-miss ports, and "exit" words, whole or damaged,
    // with every head byte count including the ones above four.
    task automatic random_datagram();
        key_t        key;
        logic [15:0] dport;
        logic [31:0] head;
        logic [2:0]  nbytes;
        int          pick;
        if ($urandom_range(0, 99) < 85)
            key = flow_keys[$urandom_range(0, POOL_KEYS - 1)];
        else
            key = {$urandom, 16'($urandom)};
        pick = $urandom_range(0, 9);
        if (pick < 8)
            dport = listen_port;
        else if (pick == 8)
            dport = 16'($urandom);
        else
            dport = listen_port ^ (16'd1 << $urandom_range(0, 15));
        pick = $urandom_range(0, 5);
        if (pick == 0)
            head = EXIT_WORD;
        else if (pick == 1)
            head = EXIT_WORD ^ (32'd1 << $urandom_range(0, 31));
        else
            head = $urandom;
        if ($urandom_range(0, 1) == 0)
            nbytes = EXIT_LEN;
        else
            nbytes = 3'($urandom_range(0, 7));
        offer(key, dport, head, nbytes);
    endtask

    initial
    begin
        int          gap_odds;
        logic [15:0] port;
        rst_n        = 1'b0;
        cfg_valid    = 1'b0;
        cfg_data     = '0;
        in_valid     = 1'b0;
        src_ip       = '0;
        src_port     = '0;
        dst_port     = '0;
        payload_head = '0;
        head_bytes   = '0;
        listen_port  = LISTEN_PORT_RESET;

        // Flow pool. Keys 1 and 2 share one half of key 0, so a match on
        // address alone or port alone must not count as a hit; keys 3 and 4
        // are the all-zero and all-ones extremes.
        for (int i = 0; i < POOL_KEYS; i++)
            flow_keys[i] = {$urandom, 16'($urandom)};
        flow_keys[1].addr = flow_keys[0].addr;
        flow_keys[2].port = flow_keys[0].port;
        flow_keys[3]      = '0;
        flow_keys[4]      = '1;

        repeat (5) @(negedge clk);
        rst_n = 1'b1;

        // Directed opening on the reset listen port.
        offer(flow_keys[0], LISTEN_PORT_RESET, 32'h6865_6C6C, 3'd4);  // new flow
        offer(flow_keys[0], LISTEN_PORT_RESET, 32'h6865_6C6C, 3'd2);  // hit, count 2
        offer(flow_keys[0], LISTEN_PORT_RESET, EXIT_WORD, EXIT_LEN);  // cleared
        offer(flow_keys[0], LISTEN_PORT_RESET, EXIT_WORD, 3'd3);      // short: counts
        offer(flow_keys[0], LISTEN_PORT_RESET, EXIT_WORD, 3'd7);      // over four: clears
        offer(flow_keys[0], LISTEN_PORT_RESET, EXIT_WORD, 3'd5);
        offer(flow_keys[1], LISTEN_PORT_RESET, 32'h0000_0001, 3'd1);  // same address
        offer(flow_keys[2], LISTEN_PORT_RESET, 32'h8000_0000, 3'd4);  // same port
        offer(flow_keys[3], LISTEN_PORT_RESET, 32'h0000_0000, 3'd0);
        offer(flow_keys[4], LISTEN_PORT_RESET, 32'hFFFF_FFFF, 3'd7);
        offer(flow_keys[0], 16'h0000, 32'h6865_6C6C, 3'd4);           // dropped
        offer(flow_keys[0], 16'hFFFF, EXIT_WORD, EXIT_LEN);           // dropped
        offer(flow_keys[0], LISTEN_PORT_RESET + 16'd1, 32'h1234_5678, 3'd4);
        offer(flow_keys[4], LISTEN_PORT_RESET, EXIT_WORD, EXIT_LEN);
        offer(flow_keys[3], LISTEN_PORT_RESET, 32'hFFFF_FFFF, 3'd6);

        // Random phases, one per listen port: reset value, both extremes,
        // a random one, then the reset value written back. The table fills
        // early on and stays full, so later phases see hits and full verdicts.
        for (int phase = 0; phase < 5; phase++)
        begin
            case (phase)
                1:       port = 16'h0000;
                2:       port = 16'hFFFF;
                3:       port = 16'($urandom);
                default: port = LISTEN_PORT_RESET;
            endcase
            if (phase > 0)
                set_listen_port(port);
            case (phase)
                1:       gap_odds = 0;    // back-to-back stretch
                2:       gap_odds = 50;
                default: gap_odds = 20;
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (phase == 4 && n == PHASE_ITEMS - CALM_ITEMS)
                    quiet = 1'b1;
                if (n == PHASE_ITEMS / 2)
                    drain();    // sender waits for the block to empty
                else if (!quiet && $urandom_range(0, 99) < gap_odds)
                    pause_sender($urandom_range(1, 17));
                random_datagram();
            end
        end

        drain();
        repeat (10) @(negedge clk);    // room for any stray reply to show up
        if (errors == 0 && awaited == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
